// ===== sv/edq_pkg.sv =====
// Shared types, constants and codes of the event dispatch queue.
package edq_pkg;

    localparam int QUEUE_CAPACITY = 15;
    localparam int LISTENER_COUNT = 8;

    localparam int QSLOTS = QUEUE_CAPACITY + 1;
    localparam int QIDX_W = $clog2(QSLOTS);
    localparam int LIDX_W = (LISTENER_COUNT > 1) ? $clog2(LISTENER_COUNT) : 1;

    localparam int EV_W = 16;
    localparam int MACH_W = 8;
    localparam int CNT_W = 4;

    typedef enum logic [2:0] {
        OP_PUSH_TAIL = 3'd0,
        OP_PUSH_HEAD = 3'd1,
        OP_POP = 3'd2,
        OP_ADD = 3'd3,
        OP_REMOVE = 3'd4,
        OP_REMOVE_MACH = 3'd5,
        OP_BROADCAST = 3'd6
    } t_op;

    typedef enum logic [1:0] {
        ST_OK = 2'd0,
        ST_EMPTY = 2'd1,
        ST_QFULL = 2'd2,
        ST_TFULL = 2'd3
    } t_status;

    typedef enum logic [1:0] {
        S_IDLE,
        S_EXEC,
        S_SCAN,
        S_DONE
    } t_state;

    // Command to the queue unit
    typedef struct packed {
        logic push_tail;
        logic push_head;
        logic pop;
        logic [EV_W-1:0] ev;
        logic [MACH_W-1:0] mach;
    } t_qcmd;

    // Write request to the subscriber table
    typedef struct packed {
        logic we;
        logic clr;
    } t_lsn_wr;

    // Compare results for the selected subscriber entry
    typedef struct packed {
        logic empty;
        logic hit_pair;
        logic hit_machine;
        logic live_match;
    } t_lsn_flags;

endpackage

// ===== sv/edq_queue.sv =====
// Circular event queue: storage, head and tail pointers, registered pop data.
module edq_queue
    import edq_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  t_qcmd             i_cmd,
    output logic              o_full,
    output logic              o_empty,
    output logic [EV_W-1:0]   o_rd_event,
    output logic [MACH_W-1:0] o_rd_machine
);

    localparam logic [QIDX_W-1:0] QLAST = QIDX_W'(QUEUE_CAPACITY);

    logic [EV_W-1:0]   r_ev_mem [QSLOTS];
    logic [MACH_W-1:0] r_m_mem [QSLOTS];
    logic [QIDX_W-1:0] r_rd, r_wr, n_rd, n_wr;
    logic [QIDX_W-1:0] w_wr_next, w_rd_next, w_rd_prev, w_waddr;
    logic              w_we, w_re;
    logic [EV_W-1:0]   r_rd_event;
    logic [MACH_W-1:0] r_rd_machine;

    assign w_wr_next = (r_wr == QLAST) ? '0 : r_wr + 1'b1;
    assign w_rd_next = (r_rd == QLAST) ? '0 : r_rd + 1'b1;
    assign w_rd_prev = (r_rd == '0) ? QLAST : r_rd - 1'b1;

    // Head and tail meet the same one-slot gap
    assign o_full = (w_wr_next == r_rd);
    assign o_empty = (r_rd == r_wr);

    always_comb begin
        n_rd = r_rd;
        n_wr = r_wr;
        w_we = 1'b0;
        w_re = 1'b0;
        w_waddr = r_wr;
        if (i_cmd.push_tail && !o_full) begin
            w_we = 1'b1;
            n_wr = w_wr_next;
        end else if (i_cmd.push_head && !o_full) begin
            w_we = 1'b1;
            w_waddr = w_rd_prev;
            n_rd = w_rd_prev;
        end else if (i_cmd.pop && !o_empty) begin
            w_re = 1'b1;
            n_rd = w_rd_next;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rd <= '0;
            r_wr <= '0;
        end else begin
            r_rd <= n_rd;
            r_wr <= n_wr;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_we) begin
            r_ev_mem[w_waddr] <= i_cmd.ev;
            r_m_mem[w_waddr] <= i_cmd.mach;
        end
        if (w_re) begin
            r_rd_event <= r_ev_mem[r_rd];
            r_rd_machine <= r_m_mem[r_rd];
        end
    end

    assign o_rd_event = r_rd_event;
    assign o_rd_machine = r_rd_machine;

endmodule

// ===== sv/edq_lsn.sv =====
// Subscriber table with the shared compare unit for the selected entry.
module edq_lsn
    import edq_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic [LIDX_W-1:0] i_idx,
    input  logic [EV_W-1:0]   i_event,
    input  logic [MACH_W-1:0] i_machine,
    input  logic [EV_W-1:0]   i_match,
    input  t_lsn_wr           i_wr,
    output t_lsn_flags        o_flags,
    output logic [MACH_W-1:0] o_entry_machine
);

    logic [EV_W-1:0]   r_ev [LISTENER_COUNT];
    logic [MACH_W-1:0] r_m [LISTENER_COUNT];
    logic [EV_W-1:0]   w_ev;
    logic [MACH_W-1:0] w_m;

    assign w_ev = r_ev[i_idx];
    assign w_m = r_m[i_idx];

    always_comb begin
        o_flags.empty = (w_m == '0);
        o_flags.hit_machine = (w_m == i_machine);
        o_flags.hit_pair = (w_m == i_machine) && (w_ev == i_event);
        o_flags.live_match = (w_m != '0) && (w_ev == i_match);
    end

    assign o_entry_machine = w_m;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < LISTENER_COUNT; k++) begin
                r_ev[k] <= '0;
                r_m[k] <= '0;
            end
        end else if (i_wr.we) begin
            r_ev[i_idx] <= i_wr.clr ? '0 : i_event;
            r_m[i_idx] <= i_wr.clr ? '0 : i_machine;
        end
    end

endmodule

// ===== sv/event_dispatch_queue.sv =====
// Top level of the event dispatch queue: sequencer, handshakes, result register.
//
// Usage: one request transaction on the s_axis side carries an operation in
// tuser (push tail, push head, pop, add subscriber, remove subscriber,
// remove machine, broadcast) and its event, machine and match event in tdata.
// Every request gives exactly one result transaction on the m_axis side:
// popped event and machine, pushed count in tdata and a status code in tuser.
// Push, pop and unused codes pass from the idle state through the execute
// and deliver states to the result register. Subscriber operations walk the
// table one entry a cycle through one shared compare unit, after the execute
// state and before the deliver state; add stops at the first empty entry,
// broadcast at the first push that finds the queue full.
// The block takes one request at a time; s_axis_tready is high only while
// the sequencer is idle, and a new request may be taken while the previous
// result still waits in the output register.
// Reset (synchronous, active low) empties the queue and clears the table.
// A stalled receiver holds the result in the output register; the next
// result waits in the deliver state until the register frees up.
module event_dispatch_queue
    import edq_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // [15:0] event_req, [23:16] machine, [39:24] match_event
    input  logic [39:0] s_axis_tdata,
    // [2:0] operation
    input  logic [2:0]  s_axis_tuser,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // [15:0] out_event, [23:16] out_machine, [27:24] pushed_count, [31:28] zero
    output logic [31:0] m_axis_tdata,
    // [1:0] status
    output logic [1:0]  m_axis_tuser
);

    localparam logic [LIDX_W-1:0] LLAST = LIDX_W'(LISTENER_COUNT - 1);

    t_state             r_state, n_state;
    t_op                r_op, n_op;
    logic [EV_W-1:0]    r_ev, n_ev;
    logic [MACH_W-1:0]  r_m, n_m;
    logic [EV_W-1:0]    r_match, n_match;
    logic [LIDX_W-1:0]  r_idx, n_idx;
    t_status            r_st, n_st;
    logic [CNT_W-1:0]   r_cnt, n_cnt;
    logic               r_popped, n_popped;

    logic               r_ovalid;
    logic [31:0]        r_odata;
    logic [1:0]         r_ouser;
    logic               w_load;

    t_qcmd              w_qcmd;
    logic               w_qfull, w_qempty;
    logic [EV_W-1:0]    w_qev;
    logic [MACH_W-1:0]  w_qm;
    t_lsn_wr            w_lwr;
    t_lsn_flags         w_lf;
    logic [MACH_W-1:0]  w_lm;

    edq_queue u_queue (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (w_qcmd),
        .o_full       (w_qfull),
        .o_empty      (w_qempty),
        .o_rd_event   (w_qev),
        .o_rd_machine (w_qm)
    );

    edq_lsn u_lsn (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_idx           (r_idx),
        .i_event         (r_ev),
        .i_machine       (r_m),
        .i_match         (r_match),
        .i_wr            (w_lwr),
        .o_flags         (w_lf),
        .o_entry_machine (w_lm)
    );

    assign s_axis_tready = (r_state == S_IDLE);

    always_comb begin
        n_state = r_state;
        n_op = r_op;
        n_ev = r_ev;
        n_m = r_m;
        n_match = r_match;
        n_idx = r_idx;
        n_st = r_st;
        n_cnt = r_cnt;
        n_popped = r_popped;
        w_qcmd = '0;
        w_qcmd.ev = r_ev;
        w_qcmd.mach = r_m;
        w_lwr = '0;
        w_load = 1'b0;

        unique case (r_state)
            S_IDLE: begin
                if (s_axis_tvalid) begin
                    // Latch the request and clear the result
                    n_op = t_op'(s_axis_tuser);
                    n_ev = s_axis_tdata[15:0];
                    n_m = s_axis_tdata[23:16];
                    n_match = s_axis_tdata[39:24];
                    n_idx = '0;
                    n_st = ST_OK;
                    n_cnt = '0;
                    n_popped = 1'b0;
                    n_state = S_EXEC;
                end
            end
            S_EXEC: begin
                n_state = S_DONE;
                unique case (r_op)
                    OP_PUSH_TAIL, OP_PUSH_HEAD: begin
                        w_qcmd.push_tail = (r_op == OP_PUSH_TAIL);
                        w_qcmd.push_head = (r_op == OP_PUSH_HEAD);
                        if (w_qfull) begin
                            n_st = ST_QFULL;
                        end else begin
                            n_cnt = CNT_W'(1);
                        end
                    end
                    OP_POP: begin
                        // Read data lands in the queue's output register next cycle
                        w_qcmd.pop = 1'b1;
                        if (w_qempty) begin
                            n_st = ST_EMPTY;
                        end else begin
                            n_popped = 1'b1;
                        end
                    end
                    OP_ADD, OP_REMOVE, OP_REMOVE_MACH, OP_BROADCAST: begin
                        n_state = S_SCAN;
                    end
                    default: begin
                        // Unused code: all-zero result
                    end
                endcase
            end
            S_SCAN: begin
                n_idx = r_idx + 1'b1;
                if (r_idx == LLAST) begin
                    n_state = S_DONE;
                end
                unique case (r_op)
                    OP_ADD: begin
                        if (w_lf.empty) begin
                            w_lwr.we = 1'b1;
                            n_state = S_DONE;
                        end else if (r_idx == LLAST) begin
                            n_st = ST_TFULL;
                        end
                    end
                    OP_REMOVE, OP_REMOVE_MACH: begin
                        if ((r_op == OP_REMOVE) ? w_lf.hit_pair : w_lf.hit_machine) begin
                            w_lwr.we = 1'b1;
                            w_lwr.clr = 1'b1;
                        end
                    end
                    default: begin
                        // Broadcast: push for each live matching entry
                        if (w_lf.live_match) begin
                            w_qcmd.push_tail = 1'b1;
                            w_qcmd.mach = w_lm;
                            if (w_qfull) begin
                                n_st = ST_QFULL;
                                n_state = S_DONE;
                            end else if (r_cnt != '1) begin
                                n_cnt = r_cnt + 1'b1;
                            end
                        end
                    end
                endcase
            end
            S_DONE: begin
                // Hand over to the output register once it is free
                if (!r_ovalid || m_axis_tready) begin
                    w_load = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_ovalid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (w_load) begin
                r_ovalid <= 1'b1;
            end else if (m_axis_tready) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    // Request and result payload: no reset needed
    always_ff @(posedge i_clk) begin
        r_op <= n_op;
        r_ev <= n_ev;
        r_m <= n_m;
        r_match <= n_match;
        r_idx <= n_idx;
        r_st <= n_st;
        r_cnt <= n_cnt;
        r_popped <= n_popped;
        if (w_load) begin
            r_odata <= {4'b0000, r_cnt,
                        r_popped ? w_qm : {MACH_W{1'b0}},
                        r_popped ? w_qev : {EV_W{1'b0}}};
            r_ouser <= r_st;
        end
    end

    assign m_axis_tvalid = r_ovalid;
    assign m_axis_tdata = r_odata;
    assign m_axis_tuser = r_ouser;

endmodule

// ===== tb/edq_scoreboard_pkg.sv =====
// Scoreboard for the event dispatch queue: queue and subscriber predictor, result check.
package edq_scoreboard_pkg;
    import edq_pkg::*;

    typedef struct {
        logic [EV_W-1:0]   ev;
        logic [MACH_W-1:0] mach;
        t_status           st;
        logic [CNT_W-1:0]  cnt;
    } t_dispatch_result;

    class dispatch_scoreboard;
        logic [EV_W-1:0]   slot_ev[QSLOTS];
        logic [MACH_W-1:0] slot_mach[QSLOTS];
        logic [QIDX_W-1:0] head;
        logic [QIDX_W-1:0] tail;
        logic [EV_W-1:0]   sub_ev[LISTENER_COUNT];
        logic [MACH_W-1:0] sub_mach[LISTENER_COUNT];
        t_dispatch_result  awaited[$];
        int                errors;

        function new();
            head = '0;
            tail = '0;
            errors = 0;
            foreach (slot_ev[i]) begin
                slot_ev[i] = '0;
                slot_mach[i] = '0;
            end
            foreach (sub_ev[i]) begin
                sub_ev[i] = '0;
                sub_mach[i] = '0;
            end
        endfunction

        function logic [QIDX_W-1:0] step_fwd(logic [QIDX_W-1:0] p);
            return (p == QIDX_W'(QSLOTS - 1)) ? '0 : p + 1'b1;
        endfunction

        function logic [QIDX_W-1:0] step_back(logic [QIDX_W-1:0] p);
            return (p == '0) ? QIDX_W'(QSLOTS - 1) : p - 1'b1;
        endfunction

        function bit enqueue_tail(logic [EV_W-1:0] ev, logic [MACH_W-1:0] m);
            if (step_fwd(tail) == head)
                return 1'b0;
            slot_ev[tail] = ev;
            slot_mach[tail] = m;
            tail = step_fwd(tail);
            return 1'b1;
        endfunction

        function bit enqueue_head(logic [EV_W-1:0] ev, logic [MACH_W-1:0] m);
            logic [QIDX_W-1:0] pv;
            pv = step_back(head);
            if (pv == tail)
                return 1'b0;
            head = pv;
            slot_ev[pv] = ev;
            slot_mach[pv] = m;
            return 1'b1;
        endfunction

        // Advance the predicted state by one accepted request and queue its result.
        function void note_request(logic [2:0] op, logic [EV_W-1:0] ev,
                                   logic [MACH_W-1:0] m, logic [EV_W-1:0] mev);
            t_dispatch_result res;
            int slot;
            res.ev = '0;
            res.mach = '0;
            res.st = ST_OK;
            res.cnt = '0;
            case (op)
                OP_PUSH_TAIL, OP_PUSH_HEAD: begin
                    if ((op == OP_PUSH_TAIL) ? enqueue_tail(ev, m) : enqueue_head(ev, m))
                        res.cnt = CNT_W'(1);
                    else
                        res.st = ST_QFULL;
                end
                OP_POP: begin
                    if (head != tail) begin
                        res.ev = slot_ev[head];
                        res.mach = slot_mach[head];
                        head = step_fwd(head);
                    end else begin
                        res.st = ST_EMPTY;
                    end
                end
                OP_ADD: begin
                    slot = -1;
                    for (int i = 0; i < LISTENER_COUNT; i++)
                        if (slot < 0 && sub_mach[i] == '0)
                            slot = i;
                    if (slot >= 0) begin
                        sub_ev[slot] = ev;
                        sub_mach[slot] = m;
                    end else begin
                        res.st = ST_TFULL;
                    end
                end
                OP_REMOVE, OP_REMOVE_MACH: begin
                    for (int i = 0; i < LISTENER_COUNT; i++)
                        if (sub_mach[i] == m && (op == OP_REMOVE_MACH || sub_ev[i] == ev)) begin
                            sub_ev[i] = '0;
                            sub_mach[i] = '0;
                        end
                end
                OP_BROADCAST: begin
                    for (int i = 0; i < LISTENER_COUNT && res.st == ST_OK; i++)
                        if (sub_mach[i] != '0 && sub_ev[i] == mev) begin
                            if (!enqueue_tail(ev, sub_mach[i]))
                                res.st = ST_QFULL;
                            else if (res.cnt != 4'hF)
                                res.cnt = res.cnt + 1'b1;
                        end
                end
                default: ;
            endcase
            awaited.push_back(res);
        endfunction

        task report_mismatch(string what, logic [31:0] got, logic [31:0] want);
            errors++;
            $display("ERROR: %s got %0h expected %0h", what, got, want);
        endtask

        // Compare one result transaction with the oldest expectation.
        task check_result(logic [31:0] data, logic [1:0] user);
            t_dispatch_result want;
            if (awaited.size() == 0) begin
                report_mismatch("result with nothing pending", data, '0);
                return;
            end
            want = awaited.pop_front();
            if (data[15:0] !== want.ev)
                report_mismatch("out_event", 32'(data[15:0]), 32'(want.ev));
            if (data[23:16] !== want.mach)
                report_mismatch("out_machine", 32'(data[23:16]), 32'(want.mach));
            if (data[27:24] !== want.cnt)
                report_mismatch("pushed_count", 32'(data[27:24]), 32'(want.cnt));
            if (data[31:28] !== 4'h0)
                report_mismatch("tdata padding", 32'(data[31:28]), '0);
            if (user !== want.st)
                report_mismatch("status", 32'(user), 32'(want.st));
        endtask

        function int pending();
            return awaited.size();
        endfunction
    endclass

endpackage

// ===== tb/tb.sv =====
// Top-level testbench of the event dispatch queue: clock, reset, stimulus and result check.
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import edq_pkg::*;
    import edq_scoreboard_pkg::*;

    // Code 7 is not a defined operation; the block must answer it with all zeros.
    localparam logic [2:0] OP_UNUSED = 3'd7;
    localparam int RANDOM_ITEMS = 850;
    localparam int DRAIN_CYCLES = 20;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    // [15:0] event_req, [23:16] machine, [39:24] match_event
    logic [39:0] s_axis_tdata = '0;
    // [2:0] operation
    logic [2:0]  s_axis_tuser = '0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    // [15:0] out_event, [23:16] out_machine, [27:24] pushed_count, [31:28] zero
    logic [31:0] m_axis_tdata;
    // [1:0] status
    logic [1:0]  m_axis_tuser;

    // Random idling on both sides while set; cleared for one long stretch.
    bit idle_on = 1'b1;

    dispatch_scoreboard sb;

    event_dispatch_queue uut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    always #4 i_clk = ~i_clk;

    // Receiver: check each accepted result transaction, then pick the next
    // ready level. Sampling right after the edge sees pre-edge values.
    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready)
            sb.check_result(m_axis_tdata, m_axis_tuser);
        m_axis_tready <= !idle_on || ($urandom_range(0, 99) >= 10);
    end

    // Offer one request transaction and hold it until accepted; record it
    // in the scoreboard at the accepting edge. Valid stays high between
    // back-to-back requests, so it gets one assignment per step.
    task automatic send_request(logic [2:0] op, logic [EV_W-1:0] ev,
                                logic [MACH_W-1:0] m, logic [EV_W-1:0] mev);
        if (idle_on && $urandom_range(0, 99) < 10) begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 3)) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser <= op;
        s_axis_tdata <= {mev, m, ev};
        @(posedge i_clk);
        while (!s_axis_tready)
            @(posedge i_clk);
        sb.note_request(op, ev, m, mev);
    endtask

    // Mostly a few event codes so that broadcasts and removals hit;
    // the rest full-range so every bit toggles.
    function automatic logic [EV_W-1:0] pick_event();
        if ($urandom_range(0, 99) < 75) begin
            case ($urandom_range(0, 3))
                0: return 16'h0001;
                1: return 16'h0002;
                2: return 16'hFFFF;
                default: return 16'h0000;
            endcase
        end
        return 16'($urandom);
    endfunction

    // Mostly a few live handles, sometimes the empty handle, sometimes anything.
    function automatic logic [MACH_W-1:0] pick_machine();
        int r;
        r = $urandom_range(0, 99);
        if (r < 8)
            return 8'h00;
        if (r < 80)
            return 8'($urandom_range(1, 4));
        return 8'($urandom);
    endfunction

    // Weight the operations by phase: fill the queue, drain it, or churn
    // the subscriber table; a small share of unused codes is noise.
    function automatic logic [2:0] pick_op(int phase_kind);
        int r;
        r = $urandom_range(0, 99);
        case (phase_kind)
            0: begin
                if (r < 35) return OP_PUSH_TAIL;
                if (r < 50) return OP_PUSH_HEAD;
                if (r < 65) return OP_BROADCAST;
                if (r < 80) return OP_POP;
            end
            1: begin
                if (r < 15) return OP_PUSH_TAIL;
                if (r < 22) return OP_PUSH_HEAD;
                if (r < 27) return OP_BROADCAST;
                if (r < 80) return OP_POP;
            end
            default: begin
                if (r < 15) return OP_PUSH_TAIL;
                if (r < 20) return OP_PUSH_HEAD;
                if (r < 40) return OP_BROADCAST;
                if (r < 60) return OP_POP;
                if (r < 80) return OP_ADD;
                if (r < 90) return OP_REMOVE;
                if (r < 97) return OP_REMOVE_MACH;
                return OP_UNUSED;
            end
        endcase
        if (r < 88) return OP_ADD;
        if (r < 93) return OP_REMOVE;
        if (r < 97) return OP_REMOVE_MACH;
        return OP_UNUSED;
    endfunction

    // Stimulus and end of run.
    initial begin
        int phase_kind;
        phase_kind = 0;
        sb = new();
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed part: empty pop, unused code, table fill and overflow,
        // broadcast into a full queue, full pushes at both ends, removals.
        send_request(OP_POP, 16'h0000, 8'h00, 16'h0000);
        send_request(OP_UNUSED, 16'hFFFF, 8'hFF, 16'hFFFF);
        // Add with the empty handle: the entry is written but stays free.
        send_request(OP_ADD, 16'h1234, 8'h00, 16'h0000);
        for (int i = 0; i < LISTENER_COUNT; i++)
            send_request(OP_ADD, 16'hFFFF, (i == LISTENER_COUNT - 1) ? 8'hFF : 8'(i + 1),
                         16'h0000);
        send_request(OP_ADD, 16'h0000, 8'h01, 16'h0000);
        // First broadcast queues one event per subscriber, second runs out of room.
        send_request(OP_BROADCAST, 16'h0000, 8'h00, 16'hFFFF);
        send_request(OP_BROADCAST, 16'hFFFF, 8'h00, 16'hFFFF);
        send_request(OP_PUSH_TAIL, 16'hA5A5, 8'h5A, 16'h0000);
        send_request(OP_PUSH_HEAD, 16'h5A5A, 8'hA5, 16'h0000);
        send_request(OP_POP, 16'h0000, 8'h00, 16'h0000);
        send_request(OP_PUSH_HEAD, 16'hFFFF, 8'h00, 16'hFFFF);
        send_request(OP_BROADCAST, 16'h5555, 8'h00, 16'h0000);
        send_request(OP_REMOVE, 16'hFFFF, 8'hFF, 16'h0000);
        send_request(OP_REMOVE, 16'h0000, 8'h00, 16'h0000);
        send_request(OP_REMOVE_MACH, 16'h0000, 8'h01, 16'h0000);
        send_request(OP_REMOVE_MACH, 16'h0000, 8'h00, 16'h0000);
        send_request(OP_POP, 16'h0000, 8'h00, 16'h0000);

        // Random part: switch the phase every 60 requests, and drop idling
        // for one long stretch in the middle.
        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            if (n % 60 == 0)
                phase_kind = $urandom_range(0, 2);
            if (n == 300)
                idle_on <= 1'b0;
            if (n == 550)
                idle_on <= 1'b1;
            send_request(pick_op(phase_kind), pick_event(), pick_machine(), pick_event());
        end
        s_axis_tvalid <= 1'b0;

        // Drain: wait for every pending result, then let the block settle.
        while (sb.pending() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (sb.errors == 0 && sb.pending() == 0)
            $display("event_dispatch_queue test passed");
        else
            $display("event_dispatch_queue test failed");
        $finish;
    end

    // Watchdog: a hung handshake ends the run as a failure.
    initial begin
        #2000000;
        $display("event_dispatch_queue test failed");
        $finish;
    end

endmodule
